/* design/amf0_pkg.sv */
// Types, key table and header constants for the AMF0 onMetaData parser.
// No dependencies.
package amf0_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       starts_tag;
	} amf0_in_t;

	typedef struct packed {
		logic [4:0]  key_id;
		logic [2:0]  kind;
		logic [63:0] value;
		logic        element_done;
	} amf0_out_t;

	localparam int NameKeep = 17;
	localparam int KeyCount = 16;
	localparam int HdrLen   = 13;

	localparam logic [2:0] KIND_NUMBER    = 3'd0;
	localparam logic [2:0] KIND_BOOLEAN   = 3'd1;
	localparam logic [2:0] KIND_STR_BYTE  = 3'd2;
	localparam logic [2:0] KIND_STR_EMPTY = 3'd3;
	localparam logic [2:0] KIND_HDR_ERR   = 3'd4;
	localparam logic [2:0] KIND_BAD_TYPE  = 3'd5;

	localparam logic [7:0] TYPE_NUMBER  = 8'h00;
	localparam logic [7:0] TYPE_BOOLEAN = 8'h01;
	localparam logic [7:0] TYPE_STRING  = 8'h02;
	localparam logic [7:0] TYPE_ECMA    = 8'h08;
	localparam logic [7:0] TYPE_LSTRING = 8'h0c;

	localparam logic [HdrLen*8-1:0] HDR_TEXT = {8'h02, 8'h00, 8'h0a, "onMetaData"};

	// key text is right-justified: first char sits at byte (len-1)
	localparam logic [NameKeep*8-1:0] KEY_TEXT [KeyCount] = '{
		"duration", "width", "height", "videodatarate", "framerate",
		"videocodecid", "audiodatarate", "audiosamplerate", "audiosamplesize",
		"stereo", "audiocodecid", {"major", "_brand"}, {"minor", "_version"},
		{"compatible", "_brands"}, "encoder", "filesize"
	};

	localparam logic [4:0] KEY_LEN [KeyCount] = '{
		5'd8, 5'd5, 5'd6, 5'd13, 5'd9, 5'd12, 5'd13, 5'd15,
		5'd15, 5'd6, 5'd12, 5'd11, 5'd13, 5'd17, 5'd7, 5'd8
	};

	function automatic logic [7:0] hdr_byte(input logic [3:0] pos);
		logic [7:0] b;
		b = 8'h00;
		for (int i = 0; i < HdrLen; i++)
			if (pos == 4'(i))
				b = HDR_TEXT[(HdrLen-1-i)*8 +: 8];
		return b;
	endfunction

	// first key, in table order, that prefixes the kept name
	function automatic logic [4:0] find_key(input logic [NameKeep-1:0][7:0] prefix,
			input logic [15:0] name_len);
		logic [4:0] id;
		logic       same;
		id = 5'd0;
		for (int k = KeyCount-1; k >= 0; k--) begin
			same = (name_len >= 16'(KEY_LEN[k]));
			for (int i = 0; i < NameKeep; i++)
				if (i < int'(KEY_LEN[k]))
					if (prefix[i] != KEY_TEXT[k][(int'(KEY_LEN[k])-1-i)*8 +: 8])
						same = 1'b0;
			if (same)
				id = 5'(k + 1);
		end
		return id;
	endfunction

endpackage

/* design/amf0_metadata_parser.sv */
// FLV script tag onMetaData parser: byte in, at most one tagged value out.
// Depends on amf0_pkg.
//
// channel   direction  handshake            payload
// byte      input      byte_valid/stall     amf0_in_t  byte_data
// res       output     res_valid/stall      amf0_out_t res_data
//
// One byte per cycle unless res_stall keeps a result waiting: a byte is
// held in the input register, then the parse step and the result register
// are updated in the same cycle.
// Reset clears all control state; the parse waits for a tag start.
// A filled input register holds while res_stall keeps a result waiting.
module amf0_metadata_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  amf0_pkg::amf0_in_t  byte_data,
	output logic               res_valid,
	input  logic               res_stall,
	output amf0_pkg::amf0_out_t res_data
);
	import amf0_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_HDR, PH_MARK, PH_COUNT, PH_NLEN, PH_NAME, PH_TYPE,
		PH_NUM, PH_BOOL, PH_SLEN, PH_LLEN, PH_STR, PH_DONE
	} phase_t;

	logic                       valid_s1;
	amf0_in_t                   in_s1;
	phase_t                     phase_q, phase_d, ph;
	logic [3:0]                 pos_q, pos_d, pos;
	logic [31:0]                elem_q, elem_d;
	logic [31:0]                cnt_q, cnt_d;
	logic [15:0]                nlen_q, nlen_d;
	logic [4:0]                 nidx_q, nidx_d;
	logic [NameKeep-1:0][7:0]   prefix_q;
	logic                       pwr;
	logic [4:0]                 key_q, key_d;
	logic [63:0]                shift_q, shift_d, shift, acc;
	logic                       emit;
	amf0_out_t                  res_d;
	logic                       can_load, step;
	logic [7:0]                 b;
	logic [31:0]                elem_dec;

	assign can_load   = !res_valid || !res_stall;
	assign step       = valid_s1 && can_load;
	assign byte_stall = valid_s1 && !can_load;
	assign b          = in_s1.data_byte;
	assign elem_dec   = elem_q - 32'd1;

	always_comb begin
		ph      = in_s1.starts_tag ? PH_HDR : phase_q;
		pos     = in_s1.starts_tag ? 4'd0 : pos_q;
		shift   = in_s1.starts_tag ? 64'd0 : shift_q;
		acc     = {shift[55:0], b};
		phase_d = ph;
		pos_d   = pos;
		shift_d = shift;
		elem_d  = in_s1.starts_tag ? 32'd0 : elem_q;
		cnt_d   = in_s1.starts_tag ? 32'd0 : cnt_q;
		nlen_d  = in_s1.starts_tag ? 16'd0 : nlen_q;
		nidx_d  = nidx_q;
		key_d   = in_s1.starts_tag ? 5'd0 : key_q;
		pwr     = 1'b0;
		emit    = 1'b0;
		res_d   = '0;
		unique case (ph)
			PH_HDR: begin
				if (pos >= 4'(HdrLen) || b != hdr_byte(pos)) begin
					phase_d = PH_DONE;
					key_d   = 5'd0;
					emit    = 1'b1;
					res_d.kind = KIND_HDR_ERR;
				end else if (pos == 4'(HdrLen - 1)) begin
					pos_d   = 4'd0;
					phase_d = PH_MARK;
				end else
					pos_d = pos + 4'd1;
			end
			PH_MARK: begin
				phase_d = (b == TYPE_ECMA) ? PH_COUNT : PH_DONE;
				pos_d   = 4'd0;
				shift_d = 64'd0;
			end
			PH_COUNT: begin
				shift_d = acc;
				pos_d   = pos + 4'd1;
				if (pos == 4'd3) begin
					elem_d  = acc[31:0];
					pos_d   = 4'd0;
					shift_d = 64'd0;
					phase_d = (acc[31:0] != 32'd0) ? PH_NLEN : PH_DONE;
				end
			end
			PH_NLEN: begin
				shift_d = acc;
				pos_d   = pos + 4'd1;
				if (pos == 4'd1) begin
					nlen_d  = acc[15:0];
					cnt_d   = {16'd0, acc[15:0]};
					nidx_d  = 5'd0;
					pos_d   = 4'd0;
					shift_d = 64'd0;
					phase_d = (acc[15:0] != 16'd0) ? PH_NAME : PH_TYPE;
				end
			end
			PH_NAME: begin
				pwr   = (nidx_q < 5'(NameKeep));
				if (pwr)
					nidx_d = nidx_q + 5'd1;
				cnt_d = cnt_q - 32'd1;
				if (cnt_q == 32'd1)
					phase_d = PH_TYPE;
			end
			PH_TYPE: begin
				key_d   = find_key(prefix_q, nlen_q);
				pos_d   = 4'd0;
				shift_d = 64'd0;
				case (b)
					TYPE_NUMBER:  phase_d = PH_NUM;
					TYPE_BOOLEAN: phase_d = PH_BOOL;
					TYPE_STRING:  phase_d = PH_SLEN;
					TYPE_LSTRING: phase_d = PH_LLEN;
					default: begin
						phase_d = PH_DONE;
						emit    = 1'b1;
						res_d.key_id = key_d;
						res_d.kind   = KIND_BAD_TYPE;
					end
				endcase
			end
			PH_NUM: begin
				shift_d = acc;
				pos_d   = pos + 4'd1;
				if (pos == 4'd7) begin
					emit  = 1'b1;
					res_d = '{key_id: key_q, kind: KIND_NUMBER, value: acc, element_done: 1'b1};
				end
			end
			PH_BOOL: begin
				emit  = 1'b1;
				res_d = '{key_id: key_q, kind: KIND_BOOLEAN, value: {63'd0, b != 8'd0},
					element_done: 1'b1};
			end
			PH_SLEN, PH_LLEN: begin
				shift_d = acc;
				pos_d   = pos + 4'd1;
				if (pos == ((ph == PH_SLEN) ? 4'd1 : 4'd3)) begin
					cnt_d   = (ph == PH_SLEN) ? {16'd0, acc[15:0]} : acc[31:0];
					pos_d   = 4'd0;
					shift_d = 64'd0;
					phase_d = PH_STR;
					if (cnt_d == 32'd0) begin
						emit  = 1'b1;
						res_d = '{key_id: key_q, kind: KIND_STR_EMPTY, value: 64'd0,
							element_done: 1'b1};
					end
				end
			end
			PH_STR: begin
				cnt_d = cnt_q - 32'd1;
				emit  = 1'b1;
				res_d = '{key_id: key_q, kind: KIND_STR_BYTE, value: {56'd0, b},
					element_done: cnt_q == 32'd1};
			end
			default: ;
		endcase
		// element finished: move to next name or stop
		if (emit && res_d.element_done) begin
			elem_d  = elem_dec;
			phase_d = (elem_dec != 32'd0) ? PH_NLEN : PH_DONE;
			pos_d   = 4'd0;
			shift_d = 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			res_valid <= 1'b0;
			phase_q   <= PH_IDLE;
			pos_q     <= 4'd0;
			elem_q    <= 32'd0;
			cnt_q     <= 32'd0;
			nlen_q    <= 16'd0;
			nidx_q    <= 5'd0;
			prefix_q  <= '0;
			key_q     <= 5'd0;
			shift_q   <= 64'd0;
		end else begin
			if (!byte_stall) begin
				valid_s1 <= byte_valid;
				if (byte_valid)
					in_s1 <= byte_data;
			end
			if (can_load)
				res_valid <= step && emit;
			if (step) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				elem_q  <= elem_d;
				cnt_q   <= cnt_d;
				nlen_q  <= nlen_d;
				nidx_q  <= nidx_d;
				key_q   <= key_d;
				shift_q <= shift_d;
				if (pwr)
					prefix_q[nidx_q] <= b;
				if (emit)
					res_data <= res_d;
			end
		end
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_HDR_ERR |->
			res_data.key_id == 5'd0 && !res_data.element_done)
		else $error("header error result carries key or done");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(res_valid && res_stall) |-> res_valid && $stable(res_data))
		else $error("stalled result changed");

endmodule
